### hdl/utld_pkg.sv
// Shared types, widths and calendar constants for the UTC to local time block.
`default_nettype none

package utld_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned OffsetW = 5;

  // Reset value of the zone offset register, in hours.
  localparam logic signed [OffsetW-1:0] OffsetReset = 5'sd8;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthMar = 4'd3;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthMay = 4'd5;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthJul = 4'd7;
  localparam logic [MonthW-1:0] MonthAug = 4'd8;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthOct = 4'd10;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [DayW-1:0] DaysLong   = 5'd31;
  localparam logic [DayW-1:0] DaysShort  = 5'd30;
  localparam logic [DayW-1:0] DaysFebLp  = 5'd29;
  localparam logic [DayW-1:0] DaysFeb    = 5'd28;

  localparam logic [HourW-1:0] HoursPerDay = 5'd24;

  // Reciprocal of 100 scaled by 2^19, rounded up. Exact for every 14-bit year.
  localparam int unsigned Recip100FracW = 19;
  localparam logic [12:0] Recip100      = 13'd5243;

  typedef struct packed {
    logic [YearW-1:0]  utc_year;
    logic [MonthW-1:0] utc_month;
    logic [DayW-1:0]   utc_day;
    logic [HourW-1:0]  utc_hour;
  } utc_stamp_t;

  typedef struct packed {
    logic [YearW-1:0]  local_year;
    logic [MonthW-1:0] local_month;
    logic [DayW-1:0]   local_day;
    logic [HourW-1:0]  local_hour;
  } local_stamp_t;

endpackage

`default_nettype wire

### hdl/utld_leap_detect.sv
// Gregorian leap year detector built on one constant multiplication.
`default_nettype none

module utld_leap_detect
  import utld_pkg::*;
(
  input  wire logic [YearW-1:0] year_i,
  output logic                  leap_o
);

  localparam int unsigned ProdW = YearW + 13;

  logic [ProdW-1:0]         prod;
  logic [Recip100FracW-1:0] frac;
  logic                     div_by_100;
  logic                     cent_div_by_4;

  // The product splits into the quotient by 100 (upper bits) and a scaled
  // remainder (lower bits); the remainder is zero exactly when the
  // fraction stays below the multiplier itself.
  assign prod          = ProdW'(year_i) * ProdW'(Recip100);
  assign frac          = prod[Recip100FracW-1:0];
  assign div_by_100    = (frac < Recip100FracW'(Recip100));
  assign cent_div_by_4 = (prod[Recip100FracW+1:Recip100FracW] == 2'b00);

  assign leap_o = div_by_100 ? cent_div_by_4 : (year_i[1:0] == 2'b00);

endmodule

`default_nettype wire

### hdl/utld_roll.sv
// Combinational hour offset and calendar day roll for one timestamp.
`default_nettype none

module utld_roll
  import utld_pkg::*;
(
  input  wire utc_stamp_t             stamp_i,
  input  wire logic signed [OffsetW-1:0] offset_i,
  input  wire logic                   leap_i,
  output local_stamp_t                stamp_o
);

  logic signed [6:0]   hour_sum;
  logic                roll_fwd;
  logic                roll_bwd;
  logic [DayW-1:0]     cur_len;
  logic [DayW-1:0]     prev_len;
  logic [DayW:0]       day_inc;
  logic [MonthW:0]     month_inc;
  logic [DayW-1:0]     feb_len;

  assign feb_len = leap_i ? DaysFebLp : DaysFeb;

  always_comb begin
    case (stamp_i.utc_month)
      MonthJan, MonthMar, MonthMay, MonthJul,
      MonthAug, MonthOct, MonthDec: cur_len = DaysLong;
      MonthApr, MonthJun, MonthSep, MonthNov: cur_len = DaysShort;
      default: cur_len = feb_len;
    endcase
  end

  always_comb begin
    case (stamp_i.utc_month)
      MonthMar: prev_len = feb_len;
      MonthMay, MonthJul, MonthOct, MonthDec: prev_len = DaysShort;
      default: prev_len = DaysLong;
    endcase
  end

  assign hour_sum  = signed'({2'b00, stamp_i.utc_hour}) + 7'(offset_i);
  assign roll_fwd  = (hour_sum >= signed'({2'b00, HoursPerDay}));
  assign roll_bwd  = (hour_sum < 7'sd0);
  assign day_inc   = {1'b0, stamp_i.utc_day} + 6'd1;
  assign month_inc = {1'b0, stamp_i.utc_month} + 5'd1;

  always_comb begin
    stamp_o.local_year  = stamp_i.utc_year;
    stamp_o.local_month = stamp_i.utc_month;
    stamp_o.local_day   = stamp_i.utc_day;
    stamp_o.local_hour  = hour_sum[HourW-1:0];
    if (roll_fwd) begin
      stamp_o.local_hour = HourW'(hour_sum - signed'({2'b00, HoursPerDay}));
      stamp_o.local_day  = day_inc[DayW-1:0];
      if (day_inc > {1'b0, cur_len}) begin
        stamp_o.local_day = DayW'(day_inc - {1'b0, cur_len});
        if (month_inc > {1'b0, MonthDec}) begin
          stamp_o.local_month = MonthW'(month_inc - {1'b0, MonthDec});
          stamp_o.local_year  = stamp_i.utc_year + YearW'(1);
        end else begin
          stamp_o.local_month = month_inc[MonthW-1:0];
        end
      end
    end else if (roll_bwd) begin
      stamp_o.local_hour = HourW'(hour_sum + signed'({2'b00, HoursPerDay}));
      if (stamp_i.utc_day > DayW'(1)) begin
        stamp_o.local_day = stamp_i.utc_day - DayW'(1);
      end else begin
        stamp_o.local_day = prev_len;
        if (stamp_i.utc_month <= MonthJan) begin
          stamp_o.local_month = MonthDec;
          stamp_o.local_year  = stamp_i.utc_year - YearW'(1);
        end else begin
          stamp_o.local_month = stamp_i.utc_month - MonthW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

### hdl/utc_to_local_date_time_core.sv
// Top level of the UTC to local date and hour converter.
// This block turns a UTC timestamp (year, month, day, hour) into local time by
// adding a signed whole-hour zone offset, then carries any overflow or
// underflow of the hour into the date: past midnight the day, month and year
// move forward, before midnight they move back to the previous day, the last
// day of the previous month, or 31 December of the previous year. Month
// lengths follow the Gregorian leap-year rule. The zone offset is a 5-bit
// two's complement register that comes out of reset at +8 hours and is
// written through the configuration beat channel; write it only while no
// beats are in flight. Each input beat is captured in an input register, the
// whole conversion (one constant multiplication for the leap-year test plus
// a few adds and compares) is combinational, and the result lands in an
// output register. One beat can be taken every cycle while the output is not
// stalled. Both stages hold their beat while the output is stalled, so the
// block still takes a new beat as long as the input stage is free.
`default_nettype none

module utc_to_local_date_time_core
  import utld_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write channel for the zone offset.
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [OffsetW-1:0]    cfg_data_i,
  // Input timestamp channel.
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire utc_stamp_t            in_data_i,
  // Output timestamp channel.
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output local_stamp_t               out_data_o
);

  logic signed [OffsetW-1:0] offset_q, offset_d;
  logic                      in_vld_q, in_vld_d;
  utc_stamp_t                in_stamp_q, in_stamp_d;
  logic                      out_vld_q, out_vld_d;
  local_stamp_t              out_stamp_q, out_stamp_d;

  logic                      out_load;
  logic                      in_load;
  logic                      leap;
  local_stamp_t              conv_stamp;

  // The register file is a single register, so writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign offset_d    = (cfg_valid_i && cfg_ready_o) ? signed'(cfg_data_i) : offset_q;

  // The output stage reloads when it is empty or its beat is being taken;
  // the input stage reloads when it is empty or can hand its beat onward.
  assign out_load   = !out_vld_q || !out_stall_i;
  assign in_load    = !in_vld_q || out_load;
  assign in_stall_o = !in_load;

  assign in_vld_d   = in_load ? in_valid_i : in_vld_q;
  assign in_stamp_d = (in_load && in_valid_i) ? in_data_i : in_stamp_q;

  assign out_vld_d   = out_load ? in_vld_q : out_vld_q;
  assign out_stamp_d = (out_load && in_vld_q) ? conv_stamp : out_stamp_q;

  utld_leap_detect u_leap (
    .year_i (in_stamp_q.utc_year),
    .leap_o (leap)
  );

  utld_roll u_roll (
    .stamp_i  (in_stamp_q),
    .offset_i (offset_q),
    .leap_i   (leap),
    .stamp_o  (conv_stamp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= OffsetReset;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      offset_q  <= offset_d;
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    in_stamp_q  <= in_stamp_d;
    out_stamp_q <= out_stamp_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_stamp_q;

endmodule

`default_nettype wire

### hdl/utld_checker.sv
// Port-level checker for the UTC to local converter, bound to the top level.
`default_nettype none

module utld_checker
  import utld_pkg::*;
(
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         in_valid_i,
  input wire logic         in_stall_o,
  input wire logic         out_valid_o,
  input wire logic         out_stall_i,
  input wire local_stamp_t out_data_o
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // The local hour is always folded into one day.
  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.local_hour < HoursPerDay))
    else $error("local hour out of range");

  // An accepted beat moves from the input register into the output register when the output is not stalled.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted beat did not reach the output");

  // With nothing waiting at the output the input side never stalls.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage is empty");

endmodule

bind utc_to_local_date_time_core utld_checker u_utld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

### tb/utc_to_local_date_time_core_tb.sv
// Self-checking testbench for the UTC to local date and hour converter.
`timescale 1ns / 100ps

module utc_to_local_date_time_core_tb;
  import utld_pkg::*;

  // The run is stopped here if the results stop arriving.
  localparam int CycleLimit = 200000;
  // Length of the long output hold-off, in cycles.
  localparam int HoldOffCycles = 60;
  // Random beats sent under each zone offset setting.
  localparam int BeatsPerSetting = 200;
  // Settle time after the last result.
  localparam int SettleCycles = 6;

  // Calendar constants as signed integers, so that compares against
  // intermediate values that may go negative stay signed.
  localparam int HoursInDay = int'(HoursPerDay);
  localparam int FirstMonth = int'(MonthJan);
  localparam int LastMonth  = int'(MonthDec);

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [OffsetW-1:0] cfg_data  = '0;

  logic         in_valid  = 1'b0;
  logic         in_stall;
  utc_stamp_t   in_data   = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  local_stamp_t out_data;

  // Timestamps waiting to be offered, and local times still owed by the block.
  utc_stamp_t   utc_pending[$];
  local_stamp_t local_owed[$];

  // Shadow copy of the zone offset register.
  logic signed [OffsetW-1:0] zone_offset = OffsetReset;

  // Idle rates in percent, set per phase by the stimulus process.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // The stimulus process flips hold_flip to request one long output hold-off;
  // the counter below owns the countdown.
  logic hold_flip = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int mismatch_count = 0;
  int cycle_count    = 0;

  utc_to_local_date_time_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic for the predictor.
  // ---------------------------------------------------------------------------

  // Gregorian rule: every 400th year is a leap year, other centuries are not.
  function automatic bit is_leap_year(logic [YearW-1:0] year);
    return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
  endfunction

  // Length of the given month. Any code outside 1..12 behaves like February.
  function automatic int days_in_month(int month, logic [YearW-1:0] year);
    case (month)
      MonthJan, MonthMar, MonthMay, MonthJul, MonthAug, MonthOct, MonthDec: begin
        return int'(DaysLong);
      end
      MonthApr, MonthJun, MonthSep, MonthNov: begin
        return int'(DaysShort);
      end
      default: begin
        return is_leap_year(year) ? int'(DaysFebLp) : int'(DaysFeb);
      end
    endcase
  endfunction

  // Length of the month before the given one. January looks back at December,
  // and every month code outside 1..12 is treated as following a long month.
  function automatic int days_in_prior_month(int month, logic [YearW-1:0] year);
    case (month)
      MonthMar: begin
        return is_leap_year(year) ? int'(DaysFebLp) : int'(DaysFeb);
      end
      MonthMay, MonthJul, MonthOct, MonthDec: begin
        return int'(DaysShort);
      end
      default: begin
        return int'(DaysLong);
      end
    endcase
  endfunction

  // Local time for one UTC stamp under the given zone offset. The hour sum
  // always lies in -16..46, so at most one day roll is ever needed. The year
  // wraps at the 14-bit field width in both directions.
  function automatic local_stamp_t to_local_time(utc_stamp_t utc,
                                                 logic signed [OffsetW-1:0] offset);
    local_stamp_t     local_time;
    logic [YearW-1:0] year;
    int               month;
    int               day;
    int               hour;
    year  = utc.utc_year;
    month = int'(utc.utc_month);
    day   = int'(utc.utc_day);
    hour  = int'(utc.utc_hour) + int'(offset);
    if (hour >= HoursInDay) begin
      hour -= HoursInDay;
      day  += 1;
      // A day beyond the month end, even one that was out of range on input,
      // is carried into the next month by the month length.
      if (day > days_in_month(month, year)) begin
        day   -= days_in_month(month, year);
        month += 1;
        if (month > LastMonth) begin
          month -= LastMonth;
          year  += 1'b1;
        end
      end
    end else if (hour < 0) begin
      hour += HoursInDay;
      day  -= 1;
      if (day < 1) begin
        day   = days_in_prior_month(month, year);
        month -= 1;
        if (month < FirstMonth) begin
          month = LastMonth;
          year  -= 1'b1;
        end
      end
    end
    local_time.local_year  = year;
    local_time.local_month = month[MonthW-1:0];
    local_time.local_day   = day[DayW-1:0];
    local_time.local_hour  = hour[HourW-1:0];
    return local_time;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic utc_stamp_t utc_stamp(int year, int month, int day, int hour);
    utc_stamp_t stamp;
    stamp.utc_year  = year[YearW-1:0];
    stamp.utc_month = month[MonthW-1:0];
    stamp.utc_day   = day[DayW-1:0];
    stamp.utc_hour  = hour[HourW-1:0];
    return stamp;
  endfunction

  // Most stamps are real calendar dates with the day and hour pushed toward
  // the month and day edges, so that rolls across months and years happen
  // often. A quarter are raw bit patterns covering every field code.
  function automatic utc_stamp_t random_utc_stamp();
    int pick;
    int year;
    int month;
    int day;
    int hour;
    pick = $urandom_range(99);
    if (pick < 25) begin
      return utc_stamp($urandom_range(16383), $urandom_range(15),
                       $urandom_range(31), $urandom_range(31));
    end
    if (pick < 35) begin
      case ($urandom_range(4))
        0:       year = 0;
        1:       year = 1;
        2:       year = 9998;
        3:       year = 9999;
        default: year = 16383;
      endcase
    end else begin
      year = $urandom_range(1, 9998);
    end
    month = $urandom_range(FirstMonth, LastMonth);
    case ($urandom_range(3))
      0:       day = 1;
      1:       day = days_in_month(month, year[YearW-1:0]);
      2:       day = days_in_month(month, year[YearW-1:0]) - 1;
      default: day = $urandom_range(1, days_in_month(month, year[YearW-1:0]));
    endcase
    case ($urandom_range(3))
      0:       hour = 0;
      1:       hour = HoursInDay - 1;
      default: hour = $urandom_range(HoursInDay - 1);
    endcase
    return utc_stamp(year, month, day, hour);
  endfunction

  // Queue one stamp for the driver. Called between clock edges so the driver
  // never sees the queue change at the edge it samples on.
  task automatic queue_stamp(utc_stamp_t stamp);
    utc_pending.push_back(stamp);
  endtask

  // Wait until every queued beat has gone in and every owed result has come
  // out, then let the pipeline settle before the register is touched.
  task automatic wait_until_drained();
    do @(posedge clk_i);
    while (utc_pending.size() != 0 || in_valid || local_owed.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One beat on the configuration channel. The shadow copy follows the write
  // at the accepting edge; the block is idle, so no prediction races it.
  task automatic write_zone_offset(int hours);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= hours[OffsetW-1:0];
    do @(posedge clk_i);
    while (!cfg_ready);
    zone_offset = hours[OffsetW-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idle_rates(int send_pct, int recv_pct);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. A new beat is chosen only once the current one has been
  // taken, so a stalled beat is held unchanged. Each accepted beat gets its
  // expected local time computed right away with the offset in force.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        local_owed.push_back(to_local_time(in_data, zone_offset));
      end
      if (!in_valid || !in_stall) begin
        if (utc_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= utc_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, counted here so the stimulus process can keep
  // feeding beats while the block backs up.
  always @(posedge clk_i) begin
    if (hold_flip != hold_seen) begin
      hold_seen <= hold_flip;
      hold_left <= HoldOffCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output monitor. Stall is drawn freshly every cycle; each accepted beat is
  // checked field by field against the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    local_stamp_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        if (local_owed.size() == 0) begin
          $error("local time beat with no input behind it: %p", out_data);
          mismatch_count++;
        end else begin
          want = local_owed.pop_front();
          check_field("local_year", want.local_year, out_data.local_year);
          check_field("local_month", want.local_month, out_data.local_month);
          check_field("local_day", want.local_day, out_data.local_day);
          check_field("local_hour", want.local_hour, out_data.local_hour);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int zone_plan[8];
    int setting;
    zone_plan = '{-12, 14, -16, 15, 0, -1, 0, 0};
    zone_plan[6] = $urandom_range(31);
    zone_plan[7] = $urandom_range(31);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sender idles often, receiver idles most of the time.
    set_idle_rates(37, 76);

    // Directed beats under the reset offset of +8 hours: mostly forward rolls.
    queue_stamp(utc_stamp(1, 1, 1, 0));
    queue_stamp(utc_stamp(9998, 12, 31, 16));     // into the new year
    queue_stamp(utc_stamp(16383, 12, 31, 23));    // year wraps to zero
    queue_stamp(utc_stamp(2000, 2, 28, 20));      // century leap year
    queue_stamp(utc_stamp(1900, 2, 28, 20));      // century, not leap
    queue_stamp(utc_stamp(2024, 2, 29, 20));
    queue_stamp(utc_stamp(2023, 4, 30, 18));
    queue_stamp(utc_stamp(2023, 4, 31, 20));      // day already past month end
    queue_stamp(utc_stamp(2023, 6, 0, 3));        // bad day, no roll
    queue_stamp(utc_stamp(2023, 0, 28, 20));      // month code zero
    queue_stamp(utc_stamp(2024, 13, 29, 20));     // month code above twelve
    queue_stamp(utc_stamp(2023, 15, 28, 23));     // month carry wraps the year
    queue_stamp(utc_stamp(16383, 15, 31, 31));    // every field at its top
    queue_stamp(utc_stamp(0, 0, 0, 0));
    wait_until_drained();

    // Mostly backward rolls under a zone offset of -12 hours.
    write_zone_offset(-12);
    @(negedge clk_i);
    queue_stamp(utc_stamp(0, 1, 1, 0));           // year wraps to the top
    queue_stamp(utc_stamp(2024, 3, 1, 5));
    queue_stamp(utc_stamp(2023, 3, 1, 5));
    queue_stamp(utc_stamp(2023, 5, 1, 0));
    queue_stamp(utc_stamp(2023, 12, 1, 11));
    queue_stamp(utc_stamp(5000, 1, 1, 3));
    queue_stamp(utc_stamp(2023, 0, 1, 0));        // month code zero goes back
    queue_stamp(utc_stamp(2023, 14, 1, 2));
    queue_stamp(utc_stamp(2023, 6, 0, 0));        // day zero rolls back
    queue_stamp(utc_stamp(2023, 8, 15, 11));
    queue_stamp(utc_stamp(2023, 8, 15, 12));

    // Random beats, one zone offset per phase: the first three phases keep
    // the current idle rates, the next three swap them, the last two idle on
    // neither side.
    for (setting = 0; setting < 8; setting++) begin
      wait_until_drained();
      write_zone_offset(zone_plan[setting]);
      if (setting == 3) begin
        set_idle_rates(76, 37);
      end else if (setting == 6) begin
        set_idle_rates(0, 0);
      end
      @(negedge clk_i);
      // Back up the block once while the sender keeps offering beats.
      if (setting == 6) begin
        hold_flip = ~hold_flip;
      end
      repeat (BeatsPerSetting) queue_stamp(random_utc_stamp());
    end

    wait_until_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### utc_to_local_date_time_core.f
hdl/utld_pkg.sv
hdl/utld_leap_detect.sv
hdl/utld_roll.sv
hdl/utc_to_local_date_time_core.sv
hdl/utld_checker.sv
tb/utc_to_local_date_time_core_tb.sv
